### sv/lat_pkg.sv
package lat_pkg;

	typedef enum logic {
		CMD_TOUCH   = 1'b0,
		CMD_COMPUTE = 1'b1
	} cmd_t;

	localparam logic [3:0] TABLE_SIZE_RESET = 4'd4;

	// shared control from the table core to every cell in the update cycle
	typedef struct packed {
		logic update;
		logic hit;
		logic evict;
	} cell_ctrl_t;

endpackage

### sv/lat_cell.sv
module lat_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                capture,
	input  logic [31:0]         cmp_addr,
	input  logic [31:0]         new_addr,
	input  logic                valid,
	input  logic                load,
	input  lat_pkg::cell_ctrl_t ctrl,
	input  logic                seen_prev,
	input  logic                seen_next,
	input  logic [31:0]         next1,
	input  logic [31:0]         next2,
	output logic [31:0]         entry,
	output logic                match,
	output logic                seen
);

	logic [31:0] entry_q;
	logic        match_q;
	logic        shift_hit;
	logic [1:0]  sel;
	logic [31:0] entry_d;

	// seen: the hit lies in this slot or an older one
	assign seen = seen_prev | match_q;

	// after an eviction the slot takes from one further up, so look at the next seen flag
	assign shift_hit = ctrl.hit & (ctrl.evict ? seen_next : seen);
	assign sel       = {1'b0, ctrl.evict} + {1'b0, shift_hit};

	always_comb begin
		case (sel)
			2'd0:    entry_d = entry_q;
			2'd1:    entry_d = next1;
			default: entry_d = next2;
		endcase
		if (load)
			entry_d = new_addr;
	end

	always_ff @(posedge clk) begin
		if (ctrl.update)
			entry_q <= entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (capture) begin
			match_q <= valid && (entry_q == cmp_addr);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

### sv/lru_address_table_core.sv
// Fully associative LRU address list held in a chain of cells, slot 0 the least recent.
// Per command the transfer cycle compares the address in every cell at once, the next
// cycle shifts the chain (each cell loads from itself or one of its two upper
// neighbors) and writes the new address; a compute hit only sets dirty. busy is high
// during that shift cycle; the result appears on the result ports with done high for
// the following cycle, in which the next command may already be started. Results
// cannot be held off: sample them whenever done is high. table_size may be written
// only while the table is idle; 0 acts as 1 and values above CAPACITY act as CAPACITY.
module lru_address_table_core #(
	parameter int CAPACITY = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] address,
	input  logic        table_size_we,
	input  logic [3:0]  table_size_wdata,
	output logic        done,
	output logic        hit,
	output logic        evicted_valid,
	output logic [31:0] evicted_address,
	output logic        dirty,
	output logic [3:0]  occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > 4) ? CW : 4;

	logic          pend_q;
	logic          done_q;
	logic [CW-1:0] count_q;
	logic          dirty_q;
	logic [3:0]    table_size_q;
	logic          hit_q;
	logic          evict_q;
	logic [31:0]   ev_addr_q;
	logic          cmd_s1;
	logic [31:0]   addr_s1;

	logic          accept;
	logic [CAPACITY+1:0] seen_ext;
	logic [31:0]   entry_ext [CAPACITY+2];
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] valid_vec;
	logic [CAPACITY-1:0] load_vec;
	logic          any_hit;
	logic          update;
	logic [LW-1:0] lim;
	logic [LW-1:0] size_ext;
	logic [LW-1:0] count_mid;
	logic          evict;
	logic [CW-1:0] count_new;
	logic          append;
	logic [CW-1:0] count_fin;
	logic [31:0]   ev_addr;
	logic [LW-1:0] occ_ext;
	lat_pkg::cell_ctrl_t ctrl;

	assign accept  = start && !pend_q;
	assign any_hit = |match_vec;
	assign update  = pend_q && !(cmd_s1 == lat_pkg::CMD_COMPUTE && any_hit);

	always_comb begin
		size_ext = LW'(table_size_q);
		if (size_ext == '0)
			lim = LW'(1);
		else if (size_ext > LW'(CAPACITY))
			lim = LW'(CAPACITY);
		else
			lim = size_ext;
	end

	assign count_mid = LW'(count_q) - LW'(any_hit);
	assign evict     = (count_mid >= lim) && (count_mid != '0);
	assign count_new = CW'(count_mid) - CW'(evict);
	assign append    = count_new < CW'(CAPACITY);
	assign count_fin = count_new + CW'(append);

	// the oldest slot is gone already when the hit sits there
	assign ev_addr = (any_hit && match_vec[0]) ? entry_ext[1] : entry_ext[0];

	assign ctrl.update = update;
	assign ctrl.hit    = any_hit;
	assign ctrl.evict  = evict;

	assign seen_ext[0] = 1'b0;
	assign seen_ext[CAPACITY+1] = seen_ext[CAPACITY];
	assign entry_ext[CAPACITY]   = '0;
	assign entry_ext[CAPACITY+1] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign valid_vec[i] = CW'(i) < count_q;
		assign load_vec[i]  = append && (CW'(i) == count_new);

		lat_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.capture   (accept),
			.cmp_addr  (address),
			.new_addr  (addr_s1),
			.valid     (valid_vec[i]),
			.load      (load_vec[i]),
			.ctrl      (ctrl),
			.seen_prev (seen_ext[i]),
			.seen_next (seen_ext[i+2]),
			.next1     (entry_ext[i+1]),
			.next2     (entry_ext[i+2]),
			.entry     (entry_ext[i]),
			.match     (match_vec[i]),
			.seen      (seen_ext[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			addr_s1 <= address;
		end
		if (pend_q) begin
			hit_q     <= any_hit;
			evict_q   <= update && evict;
			ev_addr_q <= (update && evict) ? ev_addr : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= 1'b0;
			done_q       <= 1'b0;
			count_q      <= '0;
			dirty_q      <= 1'b0;
			table_size_q <= lat_pkg::TABLE_SIZE_RESET;
		end else begin
			pend_q <= accept;
			done_q <= pend_q;
			if (table_size_we)
				table_size_q <= table_size_wdata;
			if (pend_q) begin
				if (update)
					count_q <= count_fin;
				else
					dirty_q <= 1'b1;
			end
		end
	end

	assign occ_ext = LW'(count_q);

	assign busy            = pend_q;
	assign done            = done_q;
	assign hit             = hit_q;
	assign evicted_valid   = evict_q;
	assign evicted_address = ev_addr_q;
	assign dirty           = dirty_q;
	assign occupancy       = occ_ext[3:0];

endmodule
